FILE: rtl/core/assert_macros.svh
// assertion macros shared by the allocator rtl
// expects clk and rst_n in the scope of the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define FFBA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the same cycle
`define FFBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the next cycle
`define FFBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ffba_pkg.sv
// shared types and constants of the first fit block allocator
// no dependencies
package ffba_pkg;

    localparam int CFG_W      = 17;
    localparam int ADDR_W     = 16;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic init;
        logic load;
        logic scan;
        logic next_rd;
        logic merge;
        logic shift;
        logic wr_a;
        logic wr_b;
        logic out;
    } ffba_cmd_t;

    typedef struct packed {
        logic scan_hit;
        logic scan_fail;
        logic free_op;
        logic split;
        logic shift_done;
        logic out_busy;
    } ffba_status_t;

endpackage

FILE: rtl/core/ffba_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module ffba_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/ffba_ctrl.sv
// sequencer of the allocator: init, scan, merge, shift, write and finish phases
// depends on ffba_pkg
module ffba_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ffba_pkg::ffba_status_t status,
    output ffba_pkg::ffba_cmd_t    cmd
);
    import ffba_pkg::*;

    typedef enum logic [8:0] {
        S_INIT  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_NEXT  = 9'b000001000,
        S_MERGE = 9'b000010000,
        S_SHIFT = 9'b000100000,
        S_WR_A  = 9'b001000000,
        S_WR_B  = 9'b010000000,
        S_FIN   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                // a heap_size write takes precedence, no item is taken with it
                in_ready = !cfg_we;
                if (cfg_we)
                begin
                    state_next = S_INIT;
                end
                else if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_hit)
                begin
                    state_next = status.free_op ? S_NEXT : S_SHIFT;
                end
                else if (status.scan_fail)
                begin
                    state_next = S_FIN;
                end
            end
            S_NEXT:
            begin
                cmd.next_rd = 1'b1;
                state_next  = S_MERGE;
            end
            S_MERGE:
            begin
                cmd.merge  = 1'b1;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (status.shift_done)
                begin
                    state_next = S_WR_A;
                end
            end
            S_WR_A:
            begin
                cmd.wr_a   = 1'b1;
                state_next = status.split ? S_WR_B : S_FIN;
            end
            S_WR_B:
            begin
                cmd.wr_b   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.out    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

FILE: rtl/core/ffba_datapath.sv
// block table, scan position, merge arithmetic and result register
// depends on ffba_pkg and ffba_ram
module ffba_datapath #(
    parameter int HEADER_BYTES   = 16,
    parameter int MAX_BLOCKS     = 256,
    parameter int HEAP_MAX_BYTES = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ffba_pkg::ffba_cmd_t           cmd,
    output ffba_pkg::ffba_status_t        status,
    input  logic                          cfg_we,
    input  logic [ffba_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          in_func,
    input  logic [ffba_pkg::ADDR_W-1:0]   in_size,
    input  logic [ffba_pkg::ADDR_W-1:0]   in_addr,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_ok,
    output logic [ffba_pkg::ADDR_W-1:0]   out_offset
);
    import ffba_pkg::*;

    localparam int SW   = $clog2(HEAP_MAX_BYTES + 1);
    localparam int WW   = SW + 1;
    localparam int IW   = $clog2(MAX_BLOCKS);
    localparam int CW   = $clog2(MAX_BLOCKS + 2);
    localparam int PW   = $clog2(HEAP_MAX_BYTES + 65);
    localparam int MW   = (SW > ADDR_W) ? SW : ADDR_W;
    localparam int CMPW = (PW > ADDR_W) ? PW : ADDR_W;
    localparam int LW   = (SW > CFG_W) ? SW : CFG_W;
    localparam int RST_HEAP = (65536 > HEAP_MAX_BYTES) ? HEAP_MAX_BYTES : 65536;

    localparam logic [SW-1:0]   HDR_S = SW'(HEADER_BYTES);
    localparam logic [MW-1:0]   HDR_M = MW'(HEADER_BYTES);
    localparam logic [CMPW-1:0] HDR_P = CMPW'(HEADER_BYTES);
    localparam logic [CW-1:0]   MAX_C = CW'(MAX_BLOCKS);

    // control state
    logic [SW-1:0] heap_reg;
    logic [CW-1:0] total_reg;
    logic          dv_reg;
    logic          wv_reg;
    logic          out_valid_reg;

    // payload
    logic              func_reg;
    logic [ADDR_W-1:0] size_reg, addr_reg;
    logic [CW-1:0]     rd_idx_reg;
    logic [IW-1:0]     cur_idx_reg, hit_idx_reg, main_idx_reg;
    logic [CMPW-1:0]   pos_reg;
    logic              prev_free_reg;
    logic [SW-1:0]     prev_size_reg, bs_reg, rem_reg;
    logic [WW-1:0]     main_word_reg;
    logic              split_reg, up_reg;
    logic [1:0]        r_reg;
    logic [CW-1:0]     s_reg, n_reg;
    logic [IW-1:0]     wa_reg;
    logic              res_ok_reg, out_ok_reg;
    logic [ADDR_W-1:0] res_off_reg, out_off_reg;

    logic          ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [WW-1:0] ram_wdata, ram_rdata;

    ffba_ram #(
        .WIDTH(WW),
        .DEPTH(MAX_BLOCKS)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    logic            rd_free;
    logic [SW-1:0]   rd_size;
    logic [MW-1:0]   bs_m, sz_m, diff_m;
    logic [CMPW-1:0] posh;
    logic            fits, match, hit, split_due;
    logic [LW-1:0]   cfg_ext;
    logic [SW-1:0]   heap_next;
    logic            nf;
    logic [SW-1:0]   sz1, szt;
    logic [IW-1:0]   t_idx;
    logic [1:0]      rcnt;
    logic [CW-1:0]   src0;

    assign rd_free = ram_rdata[SW];
    assign rd_size = ram_rdata[SW-1:0];
    assign bs_m    = MW'(rd_size);
    assign sz_m    = MW'(size_reg);
    assign diff_m  = bs_m - sz_m;
    assign posh    = pos_reg + HDR_P;
    assign fits    = rd_free && (bs_m >= sz_m);
    assign match   = (posh == CMPW'(addr_reg));
    assign hit     = cmd.scan && dv_reg && ((func_reg == FUNC_FREE) ? match : fits);
    assign split_due = (diff_m > HDR_M) && (total_reg < MAX_C);

    // merge with free neighbors
    assign nf    = ((CW'(hit_idx_reg) + CW'(1)) < total_reg) && rd_free;
    assign sz1   = bs_reg + (nf ? (HDR_S + rd_size) : '0);
    assign szt   = prev_free_reg ? (prev_size_reg + HDR_S + sz1) : sz1;
    assign t_idx = prev_free_reg ? (hit_idx_reg - IW'(1)) : hit_idx_reg;
    assign rcnt  = {1'b0, nf} + {1'b0, prev_free_reg};
    assign src0  = CW'(t_idx) + CW'(1) + CW'(rcnt);

    always_comb
    begin
        cfg_ext = LW'(cfg_wdata);
        if (cfg_ext > LW'(HEAP_MAX_BYTES))
        begin
            heap_next = SW'(HEAP_MAX_BYTES);
        end
        else if (cfg_ext < LW'(HEADER_BYTES))
        begin
            heap_next = HDR_S;
        end
        else
        begin
            heap_next = cfg_ext[SW-1:0];
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wa_reg;
        ram_wdata = ram_rdata;
        if (cmd.init)
        begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = {1'b1, heap_reg - HDR_S};
        end
        else if (wv_reg)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.wr_a)
        begin
            ram_we    = 1'b1;
            ram_waddr = main_idx_reg;
            ram_wdata = main_word_reg;
        end
        else if (cmd.wr_b)
        begin
            ram_we    = 1'b1;
            ram_waddr = main_idx_reg + IW'(1);
            ram_wdata = {1'b1, rem_reg};
        end
    end

    always_comb
    begin
        if (cmd.scan)
        begin
            ram_raddr = rd_idx_reg[IW-1:0];
        end
        else if (cmd.next_rd)
        begin
            ram_raddr = hit_idx_reg + IW'(1);
        end
        else
        begin
            ram_raddr = s_reg[IW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_reg      <= SW'(RST_HEAP);
            total_reg     <= CW'(1);
            dv_reg        <= 1'b0;
            wv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                heap_reg <= heap_next;
            end
            if (cmd.init)
            begin
                total_reg <= CW'(1);
            end
            else if (cmd.wr_a)
            begin
                total_reg <= total_reg + CW'(split_reg) - CW'(r_reg);
            end
            if (cmd.scan)
            begin
                dv_reg <= (rd_idx_reg < total_reg);
            end
            else
            begin
                dv_reg <= 1'b0;
            end
            wv_reg <= cmd.shift && (n_reg != '0);
            if (cmd.out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg      <= in_func;
            size_reg      <= in_size;
            addr_reg      <= in_addr;
            rd_idx_reg    <= '0;
            pos_reg       <= '0;
            prev_free_reg <= 1'b0;
            res_ok_reg    <= 1'b0;
            res_off_reg   <= '0;
        end
        if (cmd.scan)
        begin
            rd_idx_reg  <= rd_idx_reg + CW'(1);
            cur_idx_reg <= rd_idx_reg[IW-1:0];
            if (dv_reg && !hit)
            begin
                pos_reg       <= pos_reg + HDR_P + CMPW'(rd_size);
                prev_free_reg <= rd_free;
                prev_size_reg <= rd_size;
            end
            if (hit)
            begin
                hit_idx_reg  <= cur_idx_reg;
                main_idx_reg <= cur_idx_reg;
                bs_reg       <= rd_size;
                res_ok_reg   <= 1'b1;
                res_off_reg  <= (func_reg == FUNC_FREE) ? addr_reg : posh[ADDR_W-1:0];
                split_reg    <= (func_reg == FUNC_ALLOC) && split_due;
                main_word_reg <= {1'b0, split_due ? sz_m[SW-1:0] : rd_size};
                rem_reg      <= SW'(diff_m - HDR_M);
                s_reg        <= total_reg - CW'(1);
                n_reg        <= split_due ? (total_reg - CW'(1) - CW'(cur_idx_reg)) : '0;
                up_reg       <= 1'b1;
                r_reg        <= '0;
            end
        end
        if (cmd.merge)
        begin
            main_idx_reg  <= t_idx;
            main_word_reg <= {1'b1, szt};
            s_reg         <= src0;
            n_reg         <= total_reg - src0;
            up_reg        <= 1'b0;
            r_reg         <= rcnt;
            split_reg     <= 1'b0;
        end
        if (cmd.shift && (n_reg != '0))
        begin
            // alloc moves entries down from the tail, free pulls them up
            s_reg  <= up_reg ? (s_reg - CW'(1)) : (s_reg + CW'(1));
            n_reg  <= n_reg - CW'(1);
            wa_reg <= up_reg ? (s_reg[IW-1:0] + IW'(1)) : (s_reg[IW-1:0] - IW'(r_reg));
        end
        if (cmd.out)
        begin
            out_ok_reg  <= res_ok_reg;
            out_off_reg <= res_off_reg;
        end
    end

    assign status.scan_hit   = hit;
    assign status.scan_fail  = cmd.scan && !dv_reg && (rd_idx_reg >= total_reg);
    assign status.free_op    = (func_reg == FUNC_FREE);
    assign status.split      = split_reg;
    assign status.shift_done = (n_reg == '0) && !wv_reg;
    assign status.out_busy   = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign out_ok     = out_ok_reg;
    assign out_offset = out_off_reg;

endmodule

FILE: rtl/core/first_fit_block_allocator_unit.sv
// first fit block allocator: one item at a time, one result per item
// sequence: scan of the table up to the hit (on a miss over the whole entry count, then straight
//   to finish), next-entry read and merge on a free, shift of moved entries, one or two table
//   writes (the second only on a split), then finish, which stalls while the output is still full
// a new item is taken only in idle, once the previous result is in the output register; reset
//   (async, active low) and a heap_size write each write the first table entry before ready rises
`include "assert_macros.svh"
module first_fit_block_allocator_unit #(
    parameter int HEADER_BYTES   = 16,
    parameter int MAX_BLOCKS     = 256,
    parameter int HEAP_MAX_BYTES = 65536
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ffba_pkg::CFG_W-1:0]          cfg_wdata,      // heap_size
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ffba_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // req_size, free_addr
    input  logic                                s_axis_tuser,   // func
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ffba_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // data_offset
    output logic                                m_axis_tuser    // ok
);
    import ffba_pkg::*;

    ffba_cmd_t    cmd;
    ffba_status_t status;

    ffba_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    ffba_datapath #(
        .HEADER_BYTES  (HEADER_BYTES),
        .MAX_BLOCKS    (MAX_BLOCKS),
        .HEAP_MAX_BYTES(HEAP_MAX_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_func   (s_axis_tuser),
        .in_size   (s_axis_tdata[ADDR_W-1:0]),
        .in_addr   (s_axis_tdata[2*ADDR_W-1:ADDR_W]),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ok    (m_axis_tuser),
        .out_offset(m_axis_tdata)
    );

    `FFBA_ASSERT(a_cmd_onehot, $onehot0(cmd), "more than one datapath command active")
    `FFBA_ASSERT_NXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "item taken while busy")
    `FFBA_ASSERT_IMP(a_out_from_fin, $rose(m_axis_tvalid), $past(cmd.out), "result without finish")
    `FFBA_ASSERT_IMP(a_hit_fail, status.scan_hit, !status.scan_fail, "scan hit and miss together")

endmodule
